// ===== hw/rtl/ohtab_pkg.sv =====
// Shared types and constants for the open-addressing hash table.
// No dependencies; ohtab_front, ohtab_engine and the top level import this package.
`default_nettype none

package ohtab_pkg;

   localparam int OP_W     = 2;
   localparam int KEY_W    = 64;
   localparam int VAL_W    = 64;
   localparam int STATUS_W = 2;
   localparam int LIVE_W   = 11;

   typedef enum logic [OP_W-1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_MISS    = 2'd0,
      ST_OK      = 2'd1,
      ST_UPDATED = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MARK_EMPTY   = 2'd0,
      MARK_LIVE    = 2'd1,
      MARK_DELETED = 2'd2
   } mark_type;

   // one table slot as stored in the slot RAM
   typedef struct packed {
      mark_type           mark;
      logic [KEY_W-1:0]   key;
      logic [VAL_W-1:0]   value;
   } slot_type;

   // decoded request word held in the front queue
   typedef struct packed {
      op_type             op;
      logic [KEY_W-1:0]   key;
      logic [VAL_W-1:0]   value;
   } cmd_type;

   // head of the front queue as seen by the engine
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

   typedef enum logic [2:0] {
      ES_INIT,
      ES_IDLE,
      ES_READ,
      ES_EVAL,
      ES_CLEAR,
      ES_RESP
   } eng_state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ohtab_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ohtab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ohtab_front.sv =====
// Request front end: takes request words, decodes the opcode and queues them
// for the engine in a two-entry queue. Depends on ohtab_pkg.
`default_nettype none

module ohtab_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ohtab_pkg::OP_W-1:0]     req_opcode,
   input  logic [ohtab_pkg::KEY_W-1:0]    req_key,
   input  logic [ohtab_pkg::VAL_W-1:0]    req_value_in,
   input  logic                           hold,
   output ohtab_pkg::head_type            head,
   input  logic                           pop
);

   import ohtab_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               do_pop;
   cmd_type            new_cmd;

   assign req_stall = reset || hold || (count_ff == CNT_W'(DEPTH));
   assign push      = req_valid && !req_stall;
   assign do_pop    = pop && (count_ff != '0);

   always_comb begin
      new_cmd.op    = op_type'(req_opcode);
      new_cmd.key   = req_key;
      new_cmd.value = req_value_in;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== hw/rtl/ohtab_engine.sv =====
// Back end: probe sequencer over the slot RAM, live counter, clear sweep and
// the result register. Depends on ohtab_pkg and ohtab_ram.
`default_nettype none

module ohtab_engine #(
   parameter int CAPACITY = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ohtab_pkg::head_type               head,
   output logic                              pop,
   output logic                              init_busy,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ohtab_pkg::STATUS_W-1:0]    rsp_status,
   output logic [ohtab_pkg::VAL_W-1:0]       rsp_value_out,
   output logic [ohtab_pkg::LIVE_W-1:0]      rsp_live_entries
);

   import ohtab_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   eng_state_type      state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   i_ff, i_in;
   logic [IDX_W-1:0]   sq_ff, sq_in;       // i*i, low bits only
   logic               have_del_ff, have_del_in;
   logic [IDX_W-1:0]   del_idx_ff, del_idx_in;
   logic [CNT_W-1:0]   live_ff, live_in;
   status_type         status_ff, status_in;
   logic [VAL_W-1:0]   vres_ff, vres_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [VAL_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [LIVE_W-1:0]  rsp_live_ff, rsp_live_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   slot_type           wr_data;
   logic [$bits(slot_type)-1:0] rd_data;
   slot_type           rd_slot;

   logic               key_hit;
   logic               is_empty;
   logic               is_del;
   logic               at_bound;
   logic               del_seen;
   logic [IDX_W-1:0]   del_at;

   ohtab_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign rd_slot  = rd_data;
   assign key_hit  = (rd_slot.mark == MARK_LIVE) && (rd_slot.key == cmd_ff.key);
   assign is_empty = (rd_slot.mark == MARK_EMPTY);
   assign is_del   = (rd_slot.mark == MARK_DELETED);
   assign at_bound = (i_ff == LAST_IDX);
   assign del_seen = have_del_ff || is_del;
   assign del_at   = have_del_ff ? del_idx_ff : idx_ff;

   assign init_busy = (state_ff == ES_INIT);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      i_in          = i_ff;
      sq_in         = sq_ff;
      have_del_in   = have_del_ff;
      del_idx_in    = del_idx_ff;
      live_in       = live_ff;
      status_in     = status_ff;
      vres_in       = vres_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_live_in   = rsp_live_ff;
      pop           = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ES_INIT, ES_CLEAR: begin
            wr_en        = 1'b1;
            wr_data.mark = MARK_EMPTY;
            idx_in       = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in    = '0;
               live_in   = '0;
               status_in = ST_OK;
               state_in  = (state_ff == ES_INIT) ? ES_IDLE : ES_RESP;
            end
         end
         ES_IDLE: begin
            if (head.valid) begin
               pop         = 1'b1;
               cmd_in      = head.cmd;
               idx_in      = head.cmd.key[IDX_W-1:0] & LAST_IDX;
               i_in        = '0;
               sq_in       = '0;
               have_del_in = 1'b0;
               vres_in     = '0;
               status_in   = ST_MISS;
               if (head.cmd.op == OP_CLEAR) begin
                  idx_in   = '0;
                  state_in = ES_CLEAR;
               end else if ((head.cmd.op inside {OP_LOOKUP, OP_REMOVE}) &&
                            (live_ff == '0)) begin
                  state_in = ES_RESP;
               end else begin
                  state_in = ES_READ;
               end
            end
         end
         ES_READ: begin
            state_in = ES_EVAL;
         end
         ES_EVAL: begin
            if (key_hit) begin
               state_in = ES_RESP;
               case (cmd_ff.op)
                  OP_LOOKUP: begin
                     status_in = ST_OK;
                     vres_in   = rd_slot.value;
                  end
                  OP_INSERT: begin
                     wr_en         = 1'b1;
                     wr_data.mark  = MARK_LIVE;
                     wr_data.key   = cmd_ff.key;
                     wr_data.value = cmd_ff.value;
                     status_in     = ST_UPDATED;
                  end
                  OP_REMOVE: begin
                     wr_en         = 1'b1;
                     wr_data.mark  = MARK_DELETED;
                     wr_data.key   = rd_slot.key;
                     wr_data.value = rd_slot.value;
                     live_in       = live_ff - 1'b1;
                     status_in     = ST_OK;
                  end
                  default: status_in = ST_MISS;
               endcase
            end else if (is_empty || at_bound) begin
               // walk ends: empty slot or probe bound
               state_in = ES_RESP;
               if (cmd_ff.op == OP_INSERT) begin
                  if (is_empty || del_seen) begin
                     wr_en         = 1'b1;
                     wr_addr       = del_seen ? del_at : idx_ff;
                     wr_data.mark  = MARK_LIVE;
                     wr_data.key   = cmd_ff.key;
                     wr_data.value = cmd_ff.value;
                     live_in       = live_ff + 1'b1;
                     status_in     = ST_OK;
                  end else begin
                     status_in = ST_FULL;
                  end
               end else begin
                  status_in = ST_MISS;
               end
            end else begin
               if (is_del && !have_del_ff) begin
                  have_del_in = 1'b1;
                  del_idx_in  = idx_ff;
               end
               idx_in   = (idx_ff + sq_ff) & LAST_IDX;
               sq_in    = sq_ff + IDX_W'({i_ff, 1'b1});
               i_in     = i_ff + 1'b1;
               state_in = ES_READ;
            end
         end
         ES_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = vres_ff;
               rsp_live_in   = LIVE_W'(live_ff);
               state_in      = ES_IDLE;
            end
         end
         default: state_in = ES_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ES_INIT;
         idx_ff       <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      i_ff          <= i_in;
      sq_ff         <= sq_in;
      have_del_ff   <= have_del_in;
      del_idx_ff    <= del_idx_in;
      status_ff     <= status_in;
      vres_ff       <= vres_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_live_ff   <= rsp_live_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_value_out    = rsp_value_ff;
   assign rsp_live_entries = rsp_live_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/open_addressing_hash_table.sv =====
// Open-addressing key/value table with tombstones, CAPACITY slots, in one
// slot RAM (mark, 64-bit key, 64-bit value per slot, registered read).
// Requests enter a two-entry queue and a probe engine works them off one at a
// time; each produces exactly one result word. Probing starts at key & mask
// and steps idx = (idx + i*i) & mask, each slot a RAM read and then a compare,
// at most CAPACITY slots. Lookup and remove skip the walk when the live count
// is zero; clear sweeps every slot mark to empty. After reset the same sweep
// runs with req_stall held high. The result sits in an output register, so
// the engine may start the next request while a result is stalled.
// Depends on ohtab_pkg, ohtab_front, ohtab_engine, ohtab_ram.
`default_nettype none

module open_addressing_hash_table #(
   parameter int CAPACITY = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ohtab_pkg::OP_W-1:0]        req_opcode,
   input  logic [ohtab_pkg::KEY_W-1:0]       req_key,
   input  logic [ohtab_pkg::VAL_W-1:0]       req_value_in,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ohtab_pkg::STATUS_W-1:0]    rsp_status,
   output logic [ohtab_pkg::VAL_W-1:0]       rsp_value_out,
   output logic [ohtab_pkg::LIVE_W-1:0]      rsp_live_entries
);

   import ohtab_pkg::*;

   head_type   head;        // queue head toward the engine
   logic       pop;         // engine takes the head word
   logic       init_busy;   // post-reset mark sweep in progress

   // front: decode and queue request words
   ohtab_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_opcode   (req_opcode),
      .req_key      (req_key),
      .req_value_in (req_value_in),
      .hold         (init_busy),
      .head         (head),
      .pop          (pop)
   );

   // back: probe sequencer, slot RAM, counters, result register
   ohtab_engine #(
      .CAPACITY (CAPACITY)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .init_busy        (init_busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_value_out    (rsp_value_out),
      .rsp_live_entries (rsp_live_entries)
   );

   // no result can exist before the post-reset sweep finishes
   a_no_rsp_in_init : assert property (@(posedge clock) disable iff (reset)
      init_busy |-> !rsp_valid)
      else $error("result word during initial mark sweep");

   // value_out is nonzero only for a successful lookup
   a_value_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_value_out == '0)
      else $error("nonzero value_out on a non-OK result");

   // live count never exceeds the table size (when the port can show it)
   a_live_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (CAPACITY < 2048) |-> int'(rsp_live_entries) <= CAPACITY)
      else $error("live entry count exceeds capacity");

endmodule

`default_nettype wire

// ===== sim/open_addressing_hash_table_tb.sv =====
// Self-checking testbench for open_addressing_hash_table: a directed script, random
// traffic, a probe-walk fill that drives the table to full, and handshake pressure.
// Depends on ohtab_pkg and the RTL of the block; reads no files.

module open_addressing_hash_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ohtab_pkg::*;

   localparam int CAPACITY      = 1024;
   localparam int IDX_W         = $clog2(CAPACITY);
   localparam int CLOCK_PERIOD  = 10;
   localparam int RESET_CYCLES  = 6;
   localparam int IDLE_PERCENT  = 18;
   localparam int HOLD_CYCLES   = 400;
   // slowest word: a full-length probe walk
   localparam int WORD_CYCLES   = 2 * CAPACITY + 2;
   localparam int TAIL_CYCLES   = WORD_CYCLES + 8;
   localparam int QUIET_LIMIT   = 10 * WORD_CYCLES;
   localparam int ITEM_TARGET   = 1100;
   localparam int KEY_POOL_SIZE = 48;
   localparam logic [KEY_W-1:0] ALL_ONES = '1;

   // one result word as the block should report it
   typedef struct {
      status_type         status;
      logic [VAL_W-1:0]   value;
      logic [LIVE_W-1:0]  live;
   } reply_type;

   // one line of the directed script; known rows carry a hand-written reply
   typedef struct {
      op_type             op;
      logic [KEY_W-1:0]   key;
      logic [VAL_W-1:0]   value;
      bit                 known;
      status_type         status;
      logic [VAL_W-1:0]   value_out;
      logic [LIVE_W-1:0]  live;
   } script_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [OP_W-1:0]      req_opcode = '0;
   logic [KEY_W-1:0]     req_key = '0;
   logic [VAL_W-1:0]     req_value_in = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [VAL_W-1:0]     rsp_value_out;
   logic [LIVE_W-1:0]    rsp_live_entries;

   // mirror of the table contents
   mark_type             tbl_mark [CAPACITY];
   logic [KEY_W-1:0]     tbl_key [CAPACITY];
   logic [VAL_W-1:0]     tbl_value [CAPACITY];
   int unsigned          live_total;
   int unsigned          tomb_total;

   reply_type            pending_replies [$];
   reply_type            blank_reply = '{status: ST_MISS, value: '0, live: '0};
   logic [KEY_W-1:0]     key_pool [KEY_POOL_SIZE];
   int unsigned          error_count = 0;
   int unsigned          items_sent = 0;

   // sender gaps are owned by the stimulus process; receiver knobs are written
   // with NBAs at the falling edge and picked up by the sink at its next falling edge
   bit                   req_gaps = 1'b1;
   bit                   rsp_gaps = 1'b1;
   int unsigned          hold_requests = 0;

   script_row_type directed_script [24] = '{
      // empty table: lookup/remove never probe, value_in is ignored
      '{OP_LOOKUP, 64'h0, ALL_ONES, 1'b1, ST_MISS, 64'h0, 11'd0},
      '{OP_REMOVE, ALL_ONES, ALL_ONES, 1'b1, ST_MISS, 64'h0, 11'd0},
      // key zero is an ordinary key; extremes of value
      '{OP_INSERT, 64'h0, ALL_ONES, 1'b1, ST_OK, 64'h0, 11'd1},
      '{OP_LOOKUP, 64'h0, 64'h0, 1'b1, ST_OK, ALL_ONES, 11'd1},
      '{OP_INSERT, 64'h0, 64'h0123_4567_89ab_cdef, 1'b1, ST_UPDATED, 64'h0, 11'd1},
      '{OP_INSERT, ALL_ONES, 64'h0, 1'b1, ST_OK, 64'h0, 11'd2},
      '{OP_LOOKUP, ALL_ONES, 64'h0, 1'b1, ST_OK, 64'h0, 11'd2},
      // collision on slot 0, then a tombstone in front of the chain
      '{OP_INSERT, 64'h400, 64'h5, 1'b0, ST_MISS, 64'h0, 11'd0},
      '{OP_LOOKUP, 64'h400, 64'h0, 1'b0, ST_MISS, 64'h0, 11'd0},
      '{OP_REMOVE, 64'h0, 64'h0, 1'b1, ST_OK, 64'h0, 11'd2},
      '{OP_LOOKUP, 64'h0, 64'h0, 1'b0, ST_MISS, 64'h0, 11'd0},
      '{OP_LOOKUP, 64'h400, 64'h0, 1'b0, ST_MISS, 64'h0, 11'd0},
      // insert reuses the tombstone it passed
      '{OP_INSERT, 64'h800, 64'h7, 1'b0, ST_MISS, 64'h0, 11'd0},
      '{OP_REMOVE, 64'h800, 64'h0, 1'b0, ST_MISS, 64'h0, 11'd0},
      '{OP_REMOVE, 64'h800, 64'h0, 1'b0, ST_MISS, 64'h0, 11'd0},
      '{OP_INSERT, 64'h400, 64'h9, 1'b0, ST_MISS, 64'h0, 11'd0},
      '{OP_LOOKUP, 64'hffff_ffff_ffff_fc00, 64'h0, 1'b0, ST_MISS, 64'h0, 11'd0},
      '{OP_INSERT, 64'h8000_0000_0000_0000, 64'haaaa_aaaa_aaaa_aaaa, 1'b0,
        ST_MISS, 64'h0, 11'd0},
      // clear, then the table behaves as after reset
      '{OP_CLEAR, ALL_ONES, ALL_ONES, 1'b1, ST_OK, 64'h0, 11'd0},
      '{OP_LOOKUP, 64'h400, 64'h0, 1'b1, ST_MISS, 64'h0, 11'd0},
      '{OP_INSERT, 64'h400, 64'h1, 1'b1, ST_OK, 64'h0, 11'd1},
      '{OP_REMOVE, ALL_ONES, 64'h0, 1'b1, ST_MISS, 64'h0, 11'd1},
      '{OP_LOOKUP, 64'h400, 64'h0, 1'b1, ST_OK, 64'h1, 11'd1},
      '{OP_CLEAR, 64'h0, 64'h0, 1'b1, ST_OK, 64'h0, 11'd0}
   };

   open_addressing_hash_table #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_key(req_key),
      .req_value_in(req_value_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_value_out(rsp_value_out),
      .rsp_live_entries(rsp_live_entries)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------
   // Table mirror
   // ---------------------------------------------------------------------

   function automatic logic [KEY_W-1:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // random upper bits, home slot forced to the given index
   function automatic logic [KEY_W-1:0] key_at_slot(int slot);
      logic [KEY_W-1:0] k;
      k = rand64();
      k[IDX_W-1:0] = IDX_W'(slot);
      return k;
   endfunction

   function automatic int wrap_slot(logic [63:0] x);
      return int'((x & 64'(CAPACITY - 1)) % 64'(CAPACITY));
   endfunction

   function automatic void clear_table_model();
      foreach (tbl_mark[s]) tbl_mark[s] = MARK_EMPTY;
      live_total = 0;
      tomb_total = 0;
   endfunction

   // Quadratic walk from the home slot, at most CAPACITY visits. Stops on a
   // live match or an empty slot; tombstones never match but the first one
   // passed is remembered for insert.
   function automatic void find_slot(input logic [KEY_W-1:0] k, output int hit,
                                     output int stop_empty, output int first_tomb);
      int idx;
      idx = wrap_slot(k);
      hit = -1;
      stop_empty = -1;
      first_tomb = -1;
      for (int probe_n = 0; probe_n < CAPACITY; probe_n++) begin
         if (tbl_mark[idx] == MARK_EMPTY) begin
            stop_empty = idx;
            return;
         end
         if (tbl_mark[idx] == MARK_LIVE && tbl_key[idx] == k) begin
            hit = idx;
            return;
         end
         if (tbl_mark[idx] == MARK_DELETED && first_tomb < 0) first_tomb = idx;
         idx = wrap_slot(64'(idx) + 64'(probe_n) * 64'(probe_n));
      end
   endfunction

   // applies one request word to the mirror and returns the reply it causes
   function automatic reply_type apply_request(op_type op, logic [KEY_W-1:0] k,
                                               logic [VAL_W-1:0] v);
      reply_type r;
      int hit, stop_empty, first_tomb, dst;
      r.status = ST_MISS;
      r.value = '0;
      case (op)
         OP_LOOKUP: begin
            if (live_total != 0) begin
               find_slot(k, hit, stop_empty, first_tomb);
               if (hit >= 0) begin
                  r.status = ST_OK;
                  r.value = tbl_value[hit];
               end
            end
         end
         OP_INSERT: begin
            find_slot(k, hit, stop_empty, first_tomb);
            if (hit >= 0) begin
               tbl_value[hit] = v;
               r.status = ST_UPDATED;
            end else begin
               // a passed tombstone wins over the empty slot, even at the bound
               dst = (first_tomb >= 0) ? first_tomb : stop_empty;
               if (first_tomb >= 0) tomb_total--;
               if (dst >= 0) begin
                  tbl_key[dst] = k;
                  tbl_value[dst] = v;
                  tbl_mark[dst] = MARK_LIVE;
                  live_total++;
                  r.status = ST_OK;
               end else begin
                  r.status = ST_FULL;
               end
            end
         end
         OP_REMOVE: begin
            if (live_total != 0) begin
               find_slot(k, hit, stop_empty, first_tomb);
               if (hit >= 0) begin
                  tbl_mark[hit] = MARK_DELETED;
                  live_total--;
                  tomb_total++;
                  r.status = ST_OK;
               end
            end
         end
         OP_CLEAR: begin
            clear_table_model();
            r.status = ST_OK;
         end
      endcase
      r.live = LIVE_W'(live_total);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Entered at a falling edge, returns at a falling edge. Each step sees at
   // most one assignment to req_valid. The reply is worked out at the edge
   // that accepts the word.
   task automatic drive_request(input op_type op, input logic [KEY_W-1:0] k,
                                input logic [VAL_W-1:0] v, input bit known,
                                input reply_type known_reply);
      reply_type r;
      while (req_gaps && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_key      <= k;
      req_value_in <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      r = apply_request(op, k, v);
      if (known) r = known_reply;
      pending_replies.push_back(r);
      items_sent++;
      @(negedge clock);
   endtask

   // mostly pool keys so inserts, lookups and removes meet each other
   task automatic drive_random_request();
      int unsigned pick;
      op_type op;
      logic [KEY_W-1:0] k;
      logic [VAL_W-1:0] v;
      pick = $urandom_range(99);
      if (pick < 40) op = OP_INSERT;
      else if (pick < 72) op = OP_LOOKUP;
      else if (pick < 99) op = OP_REMOVE;
      else op = OP_CLEAR;
      k = ($urandom_range(4) != 0) ? key_pool[$urandom_range(KEY_POOL_SIZE - 1)] : rand64();
      case ($urandom_range(7))
         0:       v = '0;
         1:       v = ALL_ONES;
         default: v = rand64();
      endcase
      drive_request(op, k, v, 1'b0, blank_reply);
   endtask

   // sender pause: drop valid, then wait for every pending reply
   task automatic wait_replies_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_replies.size() != 0) @(negedge clock);
   endtask

   // Fill exactly the slots on one probe walk, each key placed at its own
   // home slot so every fill word is a one-probe insert. A new key with the
   // walk's home slot then runs to the bound with no empty slot: table full.
   task automatic fill_probe_walk();
      bit on_walk [CAPACITY];
      int walk_slots [$];
      logic [KEY_W-1:0] filled_keys [$];
      logic [KEY_W-1:0] stray;
      int base, idx;
      base = $urandom_range(CAPACITY - 1);
      idx = base;
      for (int probe_n = 0; probe_n < CAPACITY; probe_n++) begin
         if (!on_walk[idx]) begin
            on_walk[idx] = 1'b1;
            walk_slots.push_back(idx);
         end
         idx = wrap_slot(64'(idx) + 64'(probe_n) * 64'(probe_n));
      end
      drive_request(OP_CLEAR, rand64(), rand64(), 1'b0, blank_reply);
      foreach (walk_slots[n]) begin
         filled_keys.push_back(key_at_slot(walk_slots[n]));
         drive_request(OP_INSERT, filled_keys[n], rand64(), 1'b0, blank_reply);
      end
      // bound reached: full on insert, miss on lookup and remove
      stray = key_at_slot(base);
      drive_request(OP_INSERT, stray, rand64(), 1'b0, blank_reply);
      drive_request(OP_LOOKUP, stray, rand64(), 1'b0, blank_reply);
      drive_request(OP_REMOVE, stray, rand64(), 1'b0, blank_reply);
      drive_request(OP_LOOKUP, filled_keys[0], '0, 1'b0, blank_reply);
      drive_request(OP_LOOKUP, filled_keys[$], '0, 1'b0, blank_reply);
      // one tombstone on the walk: the next bound-length insert takes it
      drive_request(OP_REMOVE, filled_keys[filled_keys.size() / 2], '0, 1'b0,
                    blank_reply);
      drive_request(OP_INSERT, stray, rand64(), 1'b0, blank_reply);
      drive_request(OP_INSERT, key_at_slot(base), rand64(), 1'b0, blank_reply);
      drive_request(OP_LOOKUP, stray, '0, 1'b0, blank_reply);
      drive_request(OP_CLEAR, '0, '0, 1'b0, blank_reply);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   initial begin : stimulus
      script_row_type row;
      reply_type typed_reply;
      int hot_base [3];
      int late_items;
      late_items = 0;
      clear_table_model();
      // pool keys crowd onto a few home slots so chains form
      foreach (hot_base[n]) hot_base[n] = $urandom_range(CAPACITY - 1);
      key_pool[0] = '0;
      key_pool[1] = ALL_ONES;
      for (int n = 2; n < KEY_POOL_SIZE; n++) begin
         key_pool[n] = ($urandom_range(3) != 0) ? key_at_slot(hot_base[$urandom_range(2)])
                                                : rand64();
      end

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed script; the block may still be sweeping its marks here
      foreach (directed_script[n]) begin
         row = directed_script[n];
         typed_reply.status = row.status;
         typed_reply.value  = row.value_out;
         typed_reply.live   = row.live;
         drive_request(row.op, row.key, row.value, row.known, typed_reply);
      end
      wait_replies_drained();

      repeat (300) drive_random_request();

      // receiver holds off while the sender keeps offering back to back words
      hold_requests <= hold_requests + 1;
      req_gaps = 1'b0;
      repeat (40) drive_random_request();

      // no idling on either side
      rsp_gaps <= 1'b0;
      repeat (200) drive_random_request();
      rsp_gaps <= 1'b1;
      req_gaps = 1'b1;
      wait_replies_drained();

      fill_probe_walk();

      do begin
         drive_random_request();
         late_items++;
      end while (items_sent < ITEM_TARGET || late_items < 150);

      wait_replies_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------

   // stall decided at the falling edge: random, off, or a long counted hold
   initial begin : result_sink
      int unsigned hold_left;
      int unsigned hold_seen;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= rsp_gaps && ($urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   // every accepted result word is matched against the oldest pending reply
   always @(posedge clock) begin : reply_checker
      reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            $error("unexpected result word: status %0d value_out 0x%0h live_entries %0d",
                   rsp_status, rsp_value_out, rsp_live_entries);
            error_count++;
         end else begin
            want = pending_replies.pop_front();
            check_field("status", 64'(want.status), 64'(rsp_status));
            check_field("value_out", want.value, rsp_value_out);
            check_field("live_entries", 64'(want.live), 64'(rsp_live_entries));
         end
      end
   end

   // ends the run when no word moves on either channel for too long
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
